// ----- sv/sma_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and state types for the moving-average smoother.
// No dependencies; every other file of the block but sma_ram uses this package.
package sma_pkg;

	localparam int MAX_WINDOW_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// Window length register: 5 bits, reset value 2.
	localparam int LEN_CFG_W     = 5;
	localparam int LEN_CFG_RESET = 2;

	typedef enum logic {
		WIN_IDLE,
		WIN_UPDATE
	} win_state_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_HOLD
	} div_state_t;

endpackage

// ----- sv/sma_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module sma_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/sma_window.sv -----
`timescale 1ns / 1ps
// Window stage: delay line in RAM, running sum, fill count and write slot.
// Depends on sma_pkg and sma_ram; hands finished sums to the divider.
module sma_window #(
	parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF,
	parameter int LEN_W = $clog2(MAX_WINDOW + 1),
	parameter int SUM_W = SAMPLE_BITS + LEN_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [sma_pkg::LEN_CFG_W-1:0]   cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [SAMPLE_BITS-1:0]   sample,
	input  logic                            end_of_set,
	output logic                            job_valid,
	input  logic                            job_ready,
	output logic signed [SUM_W-1:0]         job_sum,
	output logic [LEN_W-1:0]                job_len,
	output logic                            job_last
);

	import sma_pkg::*;

	localparam int ADDR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int OLD_W   = ADDR_W + 1;
	localparam int LEN_RST = (LEN_CFG_RESET > MAX_WINDOW) ? MAX_WINDOW : LEN_CFG_RESET;

	win_state_t state_q, state_d;

	logic [LEN_W-1:0]              len_q;
	logic [LEN_W-1:0]              cfg_len;
	logic signed [SUM_W-1:0]       sum_q;
	logic signed [SUM_W-1:0]       sum_next;
	logic [LEN_W-1:0]              fill_q;
	logic [LEN_W-1:0]              fill_next;
	logic [ADDR_W-1:0]             slot_q;
	logic [ADDR_W-1:0]             slot_next;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic                          last_s1;
	logic                          job_valid_q;
	logic signed [SUM_W-1:0]       job_sum_q;
	logic [LEN_W-1:0]              job_len_q;
	logic                          job_last_q;

	logic                          in_fire;
	logic                          upd;
	logic                          full;
	logic                          produce;
	logic [OLD_W-1:0]              oldest_wide;
	logic [ADDR_W-1:0]             rd_addr;
	logic [SAMPLE_BITS-1:0]        rd_data;
	logic signed [SUM_W-1:0]       old_ext;

	// Length zero counts as one; lengths above the store depth saturate.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_len = LEN_W'(1);
		end else if (int'(cfg_data) > MAX_WINDOW) begin
			cfg_len = LEN_W'(MAX_WINDOW);
		end else begin
			cfg_len = LEN_W'(cfg_data);
		end
	end

	// The oldest sample sits len slots behind the write slot.
	always_comb begin
		oldest_wide = OLD_W'(slot_q) + OLD_W'(MAX_WINDOW) - OLD_W'(len_q);
		if (oldest_wide >= OLD_W'(MAX_WINDOW)) begin
			rd_addr = ADDR_W'(oldest_wide - OLD_W'(MAX_WINDOW));
		end else begin
			rd_addr = ADDR_W'(oldest_wide);
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		upd      = 1'b0;
		case (state_q)
			WIN_IDLE: begin
				in_ready = !job_valid_q;
				if (in_valid && !job_valid_q) begin
					state_d = WIN_UPDATE;
				end
			end
			WIN_UPDATE: begin
				upd     = 1'b1;
				state_d = WIN_IDLE;
			end
			default: begin
				state_d = WIN_IDLE;
			end
		endcase
	end

	assign in_fire = in_valid && in_ready;

	always_comb begin
		full      = (fill_q >= len_q);
		old_ext   = SUM_W'($signed(rd_data));
		sum_next  = sum_q + SUM_W'(sample_s1) - (full ? old_ext : SUM_W'(0));
		fill_next = full ? fill_q : fill_q + LEN_W'(1);
		produce   = (fill_next >= len_q);
		slot_next = (slot_q == ADDR_W'(MAX_WINDOW - 1)) ? '0 : slot_q + ADDR_W'(1);
	end

	// The read is issued as the word is accepted and the write lands in the update
	// state that follows, before the next read can start, so the two never collide.
	sma_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (MAX_WINDOW),
		.ADDR_W(ADDR_W)
	) u_sma_ram (
		.clk  (clk),
		.we   (upd),
		.waddr(slot_q),
		.wdata(sample_s1),
		.re   (in_fire),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WIN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LEN_W'(LEN_RST);
			sum_q       <= '0;
			fill_q      <= '0;
			slot_q      <= '0;
			job_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				len_q  <= cfg_len;
				sum_q  <= '0;
				fill_q <= '0;
				slot_q <= '0;
			end else if (upd) begin
				if (last_s1) begin
					sum_q  <= '0;
					fill_q <= '0;
					slot_q <= '0;
				end else begin
					sum_q  <= sum_next;
					fill_q <= fill_next;
					slot_q <= slot_next;
				end
			end
			if (job_valid_q && job_ready) begin
				job_valid_q <= 1'b0;
			end
			if (upd && produce) begin
				job_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= sample;
			last_s1   <= end_of_set;
		end
		if (upd && produce) begin
			job_sum_q  <= sum_next;
			job_len_q  <= len_q;
			job_last_q <= last_s1;
		end
	end

	assign job_valid = job_valid_q;
	assign job_sum   = job_sum_q;
	assign job_len   = job_len_q;
	assign job_last  = job_last_q;

endmodule

// ----- sv/sma_div.sv -----
`timescale 1ns / 1ps
// Bit-serial divider: window sum / window length, truncated toward zero,
// with the output register. Depends on sma_pkg.
module sma_div #(
	parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF,
	parameter int LEN_W = $clog2(MAX_WINDOW + 1),
	parameter int SUM_W = SAMPLE_BITS + LEN_W
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	output logic                          job_ready,
	input  logic signed [SUM_W-1:0]       job_sum,
	input  logic [LEN_W-1:0]              job_len,
	input  logic                          job_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic                          set_done
);

	import sma_pkg::*;

	localparam int CNT_W = $clog2(SUM_W + 1);

	div_state_t state_q, state_d;

	logic                   neg_q;
	logic [LEN_W-1:0]       dlen_q;
	logic [LEN_W-1:0]       rem_q;
	logic [SUM_W-1:0]       quo_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   last_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] avg_q;
	logic                   done_q;

	logic                   take;
	logic                   step;
	logic                   load_out;
	logic [LEN_W:0]         shifted;
	logic                   ge;
	logic [LEN_W-1:0]       rem_next;
	logic [SAMPLE_BITS-1:0] quo_low;
	logic [SAMPLE_BITS-1:0] avg_next;

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		take      = 1'b0;
		step      = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			DIV_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					take    = 1'b1;
					state_d = DIV_RUN;
				end
			end
			DIV_RUN: begin
				step = 1'b1;
				if (cnt_q == CNT_W'(SUM_W - 1)) begin
					state_d = DIV_HOLD;
				end
			end
			DIV_HOLD: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = DIV_IDLE;
				end
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	// One restoring step per cycle on the magnitude; the remainder stays below
	// the divisor, so it fits the length width.
	always_comb begin
		shifted  = {rem_q, quo_q[SUM_W-1]};
		ge       = (shifted >= {1'b0, dlen_q});
		rem_next = ge ? LEN_W'(shifted - {1'b0, dlen_q}) : shifted[LEN_W-1:0];
		quo_low  = quo_q[SAMPLE_BITS-1:0];
		avg_next = neg_q ? (SAMPLE_BITS'(0) - quo_low) : quo_low;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			neg_q  <= job_sum[SUM_W-1];
			quo_q  <= job_sum[SUM_W-1] ? SUM_W'(-job_sum) : SUM_W'(job_sum);
			dlen_q <= job_len;
			rem_q  <= '0;
			cnt_q  <= '0;
			last_q <= job_last;
		end else if (step) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[SUM_W-2:0], ge};
			cnt_q <= cnt_q + CNT_W'(1);
		end
		if (load_out) begin
			avg_q  <= avg_next;
			done_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign average   = avg_q;
	assign set_done  = done_q;

endmodule

// ----- sv/moving_average_smoother.sv -----
`timescale 1ns / 1ps
// Moving-average smoother top level: window stage plus divider.
// Depends on sma_pkg, sma_window, sma_div and sma_ram.
//
// Each accepted sample word passes through the window stage in its idle and
// update states: the oldest sample is read from the delay-line RAM as the word
// is accepted, and the running sum, fill count and RAM write are updated in
// the update state that follows. Once window_len samples are held, every
// sample yields one average, the window sum divided by the length and
// truncated toward zero. The division is done one quotient bit per cycle, so a
// word that yields a result keeps the divider busy through its run and hold
// states; the window stage runs the next sample while the divider works, and
// results therefore come at most once per divider pass. Words before the window
// fills produce nothing. A word with end_of_set empties the window after its own
// result, and writing window_len empties it as well; window_len 0 acts as 1 and
// values above MAX_WINDOW act as MAX_WINDOW.
// window_len may be written only while no word is in flight.
module moving_average_smoother #(
	parameter int MAX_WINDOW = sma_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sma_pkg::LEN_CFG_W-1:0] window_len,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          end_of_set,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] average,
	output logic                          set_done
);

	import sma_pkg::*;

	localparam int LEN_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = SAMPLE_BITS + LEN_W;

	logic                    job_valid;
	logic                    job_ready;
	logic signed [SUM_W-1:0] job_sum;
	logic [LEN_W-1:0]        job_len;
	logic                    job_last;

	assign cfg_ready = 1'b1;

	sma_window #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS),
		.LEN_W      (LEN_W),
		.SUM_W      (SUM_W)
	) u_sma_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (window_len),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.end_of_set(end_of_set),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job_sum   (job_sum),
		.job_len   (job_len),
		.job_last  (job_last)
	);

	sma_div #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS),
		.LEN_W      (LEN_W),
		.SUM_W      (SUM_W)
	) u_sma_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job_ready(job_ready),
		.job_sum  (job_sum),
		.job_len  (job_len),
		.job_last (job_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.average  (average),
		.set_done (set_done)
	);

endmodule

// ----- sv/sma_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the moving-average smoother, bound to the top level.
// Depends on sma_pkg for the default sample width.
module sma_checker #(
	parameter int SAMPLE_BITS = sma_pkg::SAMPLE_BITS_DEF
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] average,
	input logic                   set_done
);

	logic [7:0] pend_q;
	logic       sat_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Words accepted minus results taken; tracking stops if it ever saturates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			sat_q  <= 1'b0;
		end else if (!sat_q) begin
			if (in_acc && !out_acc) begin
				if (pend_q == 8'hFF) begin
					sat_q <= 1'b1;
				end else begin
					pend_q <= pend_q + 8'd1;
				end
			end else if (out_acc && !in_acc && pend_q != 8'd0) begin
				pend_q <= pend_q - 8'd1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(average) && $stable(set_done))
		else $error("result word changed while stalled");

	a_in_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("window stage took a word during its update cycle");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !sat_q |-> pend_q != 8'd0)
		else $error("more results than sample words");

endmodule

bind moving_average_smoother sma_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_sma_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.average  (average),
	.set_done (set_done)
);

// ----- bench/moving_average_smoother_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for moving_average_smoother: drives sample words, predicts each average.
// Depends on sma_pkg and the moving_average_smoother RTL; needs no files or arguments.
module moving_average_smoother_tb;

	import sma_pkg::*;

	localparam int SW = SAMPLE_BITS_DEF;
	localparam int MW = MAX_WINDOW_DEF;
	localparam int LW = LEN_CFG_W;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [SW-1:0] average;
		logic                 set_done;
	} mean_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [LW-1:0]        window_len;
	logic                 in_valid;
	logic                 in_ready;
	logic signed [SW-1:0] sample;
	logic                 end_of_set;
	logic                 out_valid;
	logic                 out_ready;
	logic signed [SW-1:0] average;
	logic                 set_done;

	// Shadow copy of the window state.
	int            ring [MW];
	int            ring_sum;
	int            ring_fill;
	int            ring_slot;
	logic [LW-1:0] len_reg;

	mean_t means_due [$];
	int    pending;
	int    mismatches;
	int    idle_pct;
	int    stall_left;

	moving_average_smoother DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.window_len(window_len),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.sample    (sample),
		.end_of_set(end_of_set),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.average   (average),
		.set_done  (set_done)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int span_of(input logic [LW-1:0] len);
		if (len == 0)
			return 1;
		if (len > MW)
			return MW;
		return int'(len);
	endfunction

	function automatic void clear_ring();
		ring_sum  = 0;
		ring_fill = 0;
		ring_slot = 0;
	endfunction

	// Slides one accepted sample into the shadow window and queues the average it yields.
	function automatic void slide_and_average(input logic signed [SW-1:0] s, input logic eos);
		int    span;
		mean_t m;
		span = span_of(len_reg);
		if (ring_fill >= span)
			ring_sum -= ring[(ring_slot + MW - span) % MW];
		ring_sum += int'(s);
		ring[ring_slot] = int'(s);
		ring_slot = (ring_slot + 1) % MW;
		if (ring_fill < span)
			ring_fill++;
		if (ring_fill >= span) begin
			// SystemVerilog integer division truncates toward zero, as the block does.
			m.average  = SW'(ring_sum / span);
			m.set_done = eos;
			means_due.push_back(m);
			pending++;
		end
		if (eos)
			clear_ring();
	endfunction

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(9))
			0: return {1'b0, {(SW-1){1'b1}}};
			1: return {1'b1, {(SW-1){1'b0}}};
			2: return '0;
			3: return '1;
			default: return SW'($urandom);
		endcase
	endfunction

	// Result checker.
	always @(posedge clk) begin
		mean_t m;
		if (arst_n && out_valid && out_ready) begin
			if (means_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got average %0d set_done %0b",
					$time, average, set_done);
				mismatches++;
			end else begin
				m = means_due.pop_front();
				pending--;
				if (average !== m.average) begin
					$display("%0t: average mismatch, expected %0d, got %0d",
						$time, m.average, average);
					mismatches++;
				end
				if (set_done !== m.set_done) begin
					$display("%0t: set_done mismatch, expected %0b, got %0b",
						$time, m.set_done, set_done);
					mismatches++;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready = 1'b0;
			end else begin
				out_ready = (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
			end
		end
	end

	task automatic send_word(input logic signed [SW-1:0] s, input logic eos);
		int gap;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 4);
			repeat (gap) begin
				@(negedge clk);
				in_valid   = 1'b0;
				sample     = SW'($urandom);
				end_of_set = 1'($urandom_range(1));
			end
		end
		@(negedge clk);
		in_valid   = 1'b1;
		sample     = s;
		end_of_set = eos;
		do @(posedge clk); while (!in_ready);
		slide_and_average(s, eos);
	endtask

	// Stops offering words, waits for every pending average, then lets the block go quiet.
	task automatic quiesce();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_window_len(input logic [LW-1:0] len);
		quiesce();
		@(negedge clk);
		cfg_valid  = 1'b1;
		window_len = len;
		do @(posedge clk); while (!cfg_ready);
		len_reg = len;
		clear_ring();
		@(negedge clk);
		cfg_valid  = 1'b0;
		window_len = LW'($urandom);
	endtask

	// Reset length of two: extremes, rounding toward zero, a set ending early, and a
	// length write that lands on a partly filled window.
	task automatic test_reset_length();
		idle_pct = 0;
		send_word(16'sh7FFF, 1'b0);
		send_word(16'sh7FFF, 1'b0);
		send_word(16'sh8000, 1'b0);
		send_word(16'sh8000, 1'b0);
		send_word(-16'sd1, 1'b0);
		send_word(-16'sd2, 1'b0);
		send_word(16'sd1, 1'b1);
		send_word(16'sd100, 1'b1);
		send_word(16'sd5, 1'b0);
		load_window_len(LW'(3));
		send_word(16'sd7, 1'b0);
		send_word(16'sd8, 1'b0);
		send_word(-16'sd9, 1'b1);
	endtask

	task automatic test_random_sets(input logic [LW-1:0] len, input int quota, input int pct);
		int span;
		int size;
		int done;
		logic eos;
		load_window_len(len);
		idle_pct = pct;
		span = span_of(len);
		done = 0;
		while (done < quota) begin
			// Mostly sets long enough to fill the window, some no longer than the window.
			if ($urandom_range(99) < 80)
				size = span + $urandom_range(0, span + 6);
			else
				size = $urandom_range(1, span);
			for (int k = 0; k < size; k++) begin
				eos = (k == size - 1) || ($urandom_range(49) == 0);
				send_word(pick_sample(), eos);
			end
			done += size;
		end
	endtask

	// The receiver holds off long enough that the block fills and stops taking words.
	task automatic test_backpressure();
		load_window_len(LW'(1));
		idle_pct = 20;
		@(posedge clk);
		stall_left = 400;
		for (int k = 0; k < 60; k++)
			send_word(pick_sample(), $urandom_range(7) == 0);
	endtask

	task automatic test_sender_pause();
		load_window_len(LW'(4));
		idle_pct = 20;
		for (int k = 0; k < 25; k++)
			send_word(pick_sample(), $urandom_range(9) == 0);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending != 0)
			@(posedge clk);
		for (int k = 0; k < 25; k++)
			send_word(pick_sample(), $urandom_range(9) == 0);
	endtask

	initial begin
		logic [LW-1:0] lens [11];
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		window_len = '0;
		in_valid   = 1'b0;
		sample     = '0;
		end_of_set = 1'b0;
		idle_pct   = 0;
		stall_left = 0;
		pending    = 0;
		mismatches = 0;
		len_reg    = LW'(LEN_CFG_RESET);
		clear_ring();
		lens = '{LW'(0), LW'(1), LW'(2), LW'(3), LW'(16), LW'(7), LW'(17), LW'(31),
			LW'($urandom_range(1, 31)), LW'($urandom_range(1, 31)), LW'(5)};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_length();
		for (int p = 0; p < 11; p++)
			test_random_sets(lens[p], 65, (p == 4) ? 0 : 20);
		test_backpressure();
		test_sender_pause();

		quiesce();
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
